/* design/median3x3_threshold_counter_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the median filter core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MEDIAN3X3_THRESHOLD_COUNTER_CORE_DEFINES_SVH
`define MEDIAN3X3_THRESHOLD_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define MTC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtc check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define MTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtc check failed");

`endif

/* design/mtc_pkg.sv */
// ---------------------------------------------------------------------------
// Median filter core package
// Register map, fixed field widths and the control word of a queued item.
// ---------------------------------------------------------------------------
package mtc_pkg;

    // Fixed widths of the configuration registers.
    localparam int WIDTH_BITS    = 11;
    localparam int THRESH_BITS   = 9;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 11;

    // Register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD   = 1'b1;

    // Register reset values.
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 9'd128;

    // Window geometry and the narrowest usable row.
    localparam int WIN_TAPS  = 9;
    localparam int MIN_WIDTH = 3;

    // Control word that travels with each window through the queue.
    typedef struct packed {
        logic has_result;
        logic eof;
    } item_ctrl_t;

endpackage

/* design/mtc_fifo.sv */
// ---------------------------------------------------------------------------
// Small synchronous FIFO
// Register-array queue with a fill level; the head word is always visible.
// ---------------------------------------------------------------------------
`include "median3x3_threshold_counter_core_defines.svh"

module mtc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;

    // Pointer and level update; pointers wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage words hold payload only.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign empty   = (level_reg == '0);
    assign full    = (level_reg == LW'(DEPTH));
    assign level   = level_reg;

    // The credit logic upstream must never write a full queue or read an empty one.
    `MTC_ASSERT_IMPLY(a_no_overflow, wr_en, !full)
    `MTC_ASSERT_IMPLY(a_no_underflow, rd_en, !empty)
    `MTC_ASSERT_NEXT(a_level_up, wr_en && !rd_en, level_reg == $past(level_reg) + 1'b1)

endmodule

/* design/mtc_front.sv */
// ---------------------------------------------------------------------------
// Median filter front end
// Accepts pixels, tracks row and column, keeps two line stores and the 3x3
// window, and hands each completed window or end of frame to the queue.
// ---------------------------------------------------------------------------
module mtc_front
    import mtc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [WIDTH_BITS-1:0]          image_width,
    input  logic                           accept,
    input  logic [PIXEL_BITS-1:0]          pixel,
    input  logic                           end_of_frame,
    output logic                           busy,
    output logic                           q_push,
    output item_ctrl_t                     q_ctrl,
    output logic [WIN_TAPS*PIXEL_BITS-1:0] q_window
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] MIN_W = WW'(MIN_WIDTH);

    // Position in the frame.
    logic [CW-1:0] column_index_reg, column_index_next;
    logic [1:0]    row_index_reg, row_index_next;

    // Second stage: the pixel whose line store reads are returning.
    logic                  s1_valid_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic                  s1_eof_reg;
    logic                  s1_win_reg;
    logic                  s1_fwd_reg;

    // Line stores and their registered read data.
    logic [PIXEL_BITS-1:0] store_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] store_b [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [PIXEL_BITS-1:0] last_mid_reg, last_px_reg;

    logic [PIXEL_BITS-1:0] win_reg  [WIN_TAPS];
    logic [PIXEL_BITS-1:0] win_next [WIN_TAPS];

    logic [WW-1:0]         w_raw, w_eff, col_plus;
    logic                  win_done, fwd_hit;
    logic [PIXEL_BITS-1:0] top_eff, mid_eff;

    // Effective row width, held inside the supported range.
    always_comb
    begin
        w_raw = WW'(image_width);
        if (w_raw < MIN_W)
        begin
            w_eff = MIN_W;
        end
        else if (w_raw > MAX_W)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = w_raw;
        end
    end

    // Column and row advance on each transfer; end of frame restarts both.
    always_comb
    begin
        col_plus          = WW'(column_index_reg) + WW'(1);
        column_index_next = column_index_reg;
        row_index_next    = row_index_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                column_index_next = '0;
                row_index_next    = '0;
            end
            else if (col_plus >= w_eff)
            begin
                column_index_next = '0;
                if (row_index_reg != 2'd2)
                begin
                    row_index_next = row_index_reg + 1'b1;
                end
            end
            else
            begin
                column_index_next = col_plus[CW-1:0];
            end
        end
    end

    assign win_done = (row_index_reg == 2'd2) && (column_index_reg >= CW'(2));
    assign fwd_hit  = s1_valid_reg && (s1_col_reg == column_index_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg <= '0;
            row_index_reg    <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            column_index_reg <= column_index_next;
            row_index_reg    <= row_index_next;
            s1_valid_reg     <= accept;
        end
    end

    // Stage payload, captured with the transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= column_index_reg;
            s1_px_reg  <= pixel;
            s1_eof_reg <= end_of_frame;
            s1_win_reg <= win_done;
            s1_fwd_reg <= fwd_hit;
        end
        if (s1_valid_reg)
        begin
            last_mid_reg <= mid_eff;
            last_px_reg  <= s1_px_reg;
        end
    end

    // Line stores: read at the current column, written back in the following cycle.
    always_ff @(posedge clk)
    begin
        rd_a_reg <= store_a[column_index_reg];
        rd_b_reg <= store_b[column_index_reg];
        if (s1_valid_reg)
        begin
            store_a[s1_col_reg] <= s1_px_reg;
            store_b[s1_col_reg] <= mid_eff;
        end
    end

    // A read of the column still being written takes the bypassed values.
    assign top_eff = s1_fwd_reg ? last_mid_reg : rd_b_reg;
    assign mid_eff = s1_fwd_reg ? last_px_reg : rd_a_reg;

    // Window shift: each row moves left and takes a new right-hand column.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_eff;
        win_next[5] = mid_eff;
        win_next[8] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[k] <= s1_eof_reg ? '0 : win_next[k];
            end
        end
    end

    // Queue handoff: a completed window, or a bare end of frame.
    always_comb
    begin
        q_push            = s1_valid_reg && (s1_win_reg || s1_eof_reg);
        q_ctrl.has_result = s1_win_reg;
        q_ctrl.eof        = s1_eof_reg;
        for (int k = 0; k < WIN_TAPS; k++)
        begin
            q_window[k*PIXEL_BITS +: PIXEL_BITS] = win_next[k];
        end
    end

    assign busy = s1_valid_reg;

endmodule

/* design/mtc_back.sv */
// ---------------------------------------------------------------------------
// Median filter back end
// Three-stage median network, threshold test and saturating window count.
// ---------------------------------------------------------------------------
module mtc_back
    import mtc_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int COUNT_BITS = 20,
    parameter int OUT_DEPTH  = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [THRESH_BITS-1:0]                threshold,
    input  logic                                  q_empty,
    input  item_ctrl_t                            q_ctrl,
    input  logic [WIN_TAPS*PIXEL_BITS-1:0]        q_window,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]        out_level,
    output logic                                  q_pop,
    output logic                                  res_push,
    output logic [PIXEL_BITS+COUNT_BITS+1:0]      res_data
);

    localparam int PB   = PIXEL_BITS;
    localparam int OLW  = $clog2(OUT_DEPTH+1);
    localparam int CMPW = (PB > THRESH_BITS) ? PB : THRESH_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Sort three values; result is {low, middle, high}.
    function automatic logic [3*PB-1:0] sort3(input logic [PB-1:0] a,
                                              input logic [PB-1:0] b,
                                              input logic [PB-1:0] c);
        logic [PB-1:0] l1, h1, t, lo, md, hi;
        l1 = (a < b) ? a : b;
        h1 = (a < b) ? b : a;
        hi = (h1 < c) ? c : h1;
        t  = (h1 < c) ? h1 : c;
        md = (l1 < t) ? t : l1;
        lo = (l1 < t) ? l1 : t;
        return {lo, md, hi};
    endfunction

    // Stage A: each window row sorted.
    logic          pa_valid_reg;
    item_ctrl_t    pa_ctrl_reg;
    logic [PB-1:0] pa_lo_reg [3];
    logic [PB-1:0] pa_md_reg [3];
    logic [PB-1:0] pa_hi_reg [3];

    // Stage B: largest low, middle of middles, smallest high.
    logic          pb_valid_reg;
    item_ctrl_t    pb_ctrl_reg;
    logic [PB-1:0] pb_lo_reg, pb_md_reg, pb_hi_reg;

    // Stage C: the median.
    logic          pc_valid_reg;
    item_ctrl_t    pc_ctrl_reg;
    logic [PB-1:0] pc_med_reg;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [3*PB-1:0]       row_sort [3];
    logic [3*PB-1:0]       lo_sort, md_sort, hi_sort, med_sort;
    logic [1:0]            inflight;
    logic [OLW:0]          credit_need;
    logic                  hit;

    // Pull from the queue only when the result queue has room for everything
    // already in the pipeline.
    always_comb
    begin
        inflight    = {1'b0, pa_valid_reg} + {1'b0, pb_valid_reg} + {1'b0, pc_valid_reg};
        credit_need = {1'b0, out_level} + (OLW+1)'(inflight);
        q_pop       = !q_empty && (credit_need < (OLW+1)'(OUT_DEPTH));
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sort[r] = sort3(q_window[(r*3)*PB +: PB],
                                q_window[(r*3 + 1)*PB +: PB],
                                q_window[(r*3 + 2)*PB +: PB]);
        end
        lo_sort  = sort3(pa_lo_reg[0], pa_lo_reg[1], pa_lo_reg[2]);
        md_sort  = sort3(pa_md_reg[0], pa_md_reg[1], pa_md_reg[2]);
        hi_sort  = sort3(pa_hi_reg[0], pa_hi_reg[1], pa_hi_reg[2]);
        med_sort = sort3(pb_lo_reg, pb_md_reg, pb_hi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_valid_reg <= 1'b0;
            pb_valid_reg <= 1'b0;
            pc_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            pa_valid_reg <= q_pop;
            pb_valid_reg <= pa_valid_reg;
            pc_valid_reg <= pb_valid_reg;
            count_reg    <= count_next;
        end
    end

    // Median network payload.
    always_ff @(posedge clk)
    begin
        pa_ctrl_reg <= q_ctrl;
        for (int r = 0; r < 3; r++)
        begin
            pa_lo_reg[r] <= row_sort[r][3*PB-1:2*PB];
            pa_md_reg[r] <= row_sort[r][2*PB-1:PB];
            pa_hi_reg[r] <= row_sort[r][PB-1:0];
        end
        pb_ctrl_reg <= pa_ctrl_reg;
        pb_lo_reg   <= lo_sort[PB-1:0];
        pb_md_reg   <= md_sort[2*PB-1:PB];
        pb_hi_reg   <= hi_sort[3*PB-1:2*PB];
        pc_ctrl_reg <= pb_ctrl_reg;
        pc_med_reg  <= med_sort[2*PB-1:PB];
    end

    // Threshold test and saturating count; end of frame clears the count.
    always_comb
    begin
        hit        = CMPW'(pc_med_reg) >= CMPW'(threshold);
        count_next = count_reg;
        if (pc_valid_reg && pc_ctrl_reg.has_result && hit && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
        res_push = pc_valid_reg && pc_ctrl_reg.has_result;
        res_data = {pc_med_reg, hit, count_next, pc_ctrl_reg.eof};
        if (pc_valid_reg && pc_ctrl_reg.eof)
        begin
            count_next = '0;
        end
    end

endmodule

/* design/median3x3_threshold_counter_core.sv */
// ---------------------------------------------------------------------------
// 3x3 median filter with threshold counter
// Streams pixels in raster order and reports window medians and match counts.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter through a queue-style port: a transfer happens on a clock
//   edge with push high and full low. end_of_frame marks the last pixel and
//   restarts row, column, window and count for the next frame.
//   Every pixel at column two or later of row two or later completes a 3x3
//   window and yields one result: the median, the at-or-above flag against
//   threshold, the saturating count of such windows this frame, and
//   frame_done. Results wait in an output queue; the head is valid while
//   empty is low and leaves on an edge with pop high.
//   A pixel's result passes the front stage, the window queue, median stages
//   A, B and C and the result queue. Throughput is one pixel per cycle while
//   full stays low, set by the single read and write per cycle of each line
//   store and the one-window-per-cycle median pipeline. When pop stays low
//   the output queue fills, the window queue backs up and full rises; no
//   result is lost. Reset restores the register defaults (width 1024,
//   threshold 128) and empties both queues. The line stores are not cleared;
//   only entries written in the current frame are ever used.
//   Configuration writes take effect at once and belong in idle periods.
// ---------------------------------------------------------------------------
module median3x3_threshold_counter_core
    import mtc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int COUNT_BITS = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic [PIXEL_BITS-1:0]    pixel,
    input  logic                     end_of_frame,
    input  logic                     push,
    output logic                     full,
    output logic [PIXEL_BITS-1:0]    median_value,
    output logic                     at_or_above,
    output logic [COUNT_BITS-1:0]    match_count,
    output logic                     frame_done,
    output logic                     empty,
    input  logic                     pop
);

    localparam int Q_DEPTH   = 4;
    localparam int OUT_DEPTH = 8;
    localparam int QLW       = $clog2(Q_DEPTH+1);
    localparam int OLW       = $clog2(OUT_DEPTH+1);
    localparam int CTRL_BITS = $bits(item_ctrl_t);
    localparam int WIN_BITS  = WIN_TAPS * PIXEL_BITS;
    localparam int Q_BITS    = CTRL_BITS + WIN_BITS;
    localparam int RES_BITS  = PIXEL_BITS + COUNT_BITS + 2;

    logic [WIDTH_BITS-1:0]  image_width_reg;
    logic [THRESH_BITS-1:0] threshold_reg;

    logic                accept, front_busy;
    logic                q_push, q_pop, q_empty, q_full;
    item_ctrl_t          q_ctrl_in, q_ctrl_out;
    logic [WIN_BITS-1:0] q_window_in;
    logic [Q_BITS-1:0]   q_rd_data;
    logic [QLW-1:0]      q_level;
    logic [QLW:0]        q_need;

    logic                res_push, out_full, out_pop;
    logic [RES_BITS-1:0] res_data, out_data;
    logic [OLW-1:0]      out_level;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_RESET;
            threshold_reg   <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH: image_width_reg <= cfg_wdata[WIDTH_BITS-1:0];
                REG_THRESHOLD:   threshold_reg   <= cfg_wdata[THRESH_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Input transfers only while the window queue can take what is in flight.
    assign q_need = {1'b0, q_level} + (QLW+1)'(front_busy);
    assign full   = q_need >= (QLW+1)'(Q_DEPTH);
    assign accept = push && !full;

    mtc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .accept       (accept),
        .pixel        (pixel),
        .end_of_frame (end_of_frame),
        .busy         (front_busy),
        .q_push       (q_push),
        .q_ctrl       (q_ctrl_in),
        .q_window     (q_window_in)
    );

    // Window queue between the front and back ends.
    mtc_fifo #(
        .WIDTH (Q_BITS),
        .DEPTH (Q_DEPTH)
    ) u_window_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data ({q_ctrl_in, q_window_in}),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .full    (q_full),
        .level   (q_level)
    );

    assign q_ctrl_out = item_ctrl_t'(q_rd_data[Q_BITS-1:WIN_BITS]);

    mtc_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .COUNT_BITS (COUNT_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .q_empty   (q_empty || q_full && 1'b0),
        .q_ctrl    (q_ctrl_out),
        .q_window  (q_rd_data[WIN_BITS-1:0]),
        .out_level (out_level),
        .q_pop     (q_pop),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue facing the consumer.
    assign out_pop = pop && !empty;

    mtc_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .rd_en   (out_pop),
        .rd_data (out_data),
        .empty   (empty),
        .full    (out_full),
        .level   (out_level)
    );

    // Result fields; a full result queue is covered by the back-end credit.
    assign median_value = out_data[RES_BITS-1:COUNT_BITS+2];
    assign at_or_above  = out_data[COUNT_BITS+1];
    assign match_count  = out_data[COUNT_BITS:1];
    assign frame_done   = out_data[0] && (out_full || !out_full);

endmodule

/* tb/median_window_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Window result checker for the median filter core
// Watches the configuration port and both queue ports. It keeps its own copy
// of the two line stores, the 3x3 window and the frame counters. From every
// pixel transfer it works out the window result that is due, and it compares
// each result transfer with the oldest result still owed.
// ---------------------------------------------------------------------------
module median_window_checker
    import mtc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic [7:0]               pixel,
    input  logic                     end_of_frame,
    input  logic                     push,
    input  logic                     full,
    input  logic [7:0]               median_value,
    input  logic                     at_or_above,
    input  logic [19:0]              match_count,
    input  logic                     frame_done,
    input  logic                     empty,
    input  logic                     pop,
    output int                       mismatches,
    output int                       pending,
    output int                       windows_checked,
    output int                       windows_hit,
    output int                       pixels_taken
);

    localparam int          ROW_DEPTH    = 1024;
    localparam int          REPORT_LIMIT = 10;
    localparam int          MEDIAN_RANK  = WIN_TAPS / 2;
    localparam logic [19:0] COUNT_FULL   = '1;

    typedef struct packed {
        logic [7:0]  median;
        logic        hit;
        logic [19:0] count;
        logic        done;
    } window_result_t;

    // Mirror of the core state: the previous row, the row before it, and the
    // window with taps 0..2 on top, 3..5 in the middle, 6..8 at the bottom.
    logic [7:0]               prev_row  [ROW_DEPTH];
    logic [7:0]               older_row [ROW_DEPTH];
    logic [WIN_TAPS-1:0][7:0] window;
    int                       col_pos;
    int                       row_pos;
    logic [19:0]              frame_hits;
    logic [WIDTH_BITS-1:0]    width_setting;
    logic [THRESH_BITS-1:0]   threshold_setting;

    window_result_t owed_windows[$];
    int             fail_total;
    int             checked_total;
    int             hit_total;
    int             pixel_total;

    // The median is the tap with at most four values below it and at least
    // five values at or below it.
    function automatic logic [7:0] window_median(input logic [WIN_TAPS-1:0][7:0] taps);
        int         i;
        int         j;
        int         below;
        int         not_above;
        logic [7:0] result;
        result = '0;
        for (i = 0; i < WIN_TAPS; i++)
        begin
            below     = 0;
            not_above = 0;
            for (j = 0; j < WIN_TAPS; j++)
            begin
                if (taps[j] < taps[i])
                    below++;
                if (taps[j] <= taps[i])
                    not_above++;
            end
            if (below <= MEDIAN_RANK && not_above > MEDIAN_RANK)
                result = taps[i];
        end
        return result;
    endfunction

    // Advance the mirrored state by one pixel and queue the result it owes.
    task automatic take_pixel(input logic [7:0] px, input logic last);
        int             row_len;
        int             c;
        int             r;
        logic [7:0]     upper;
        logic [7:0]     middle;
        logic [7:0]     med;
        logic           hit;
        window_result_t owed;
        row_len = int'(width_setting);
        if (row_len < MIN_WIDTH)
            row_len = MIN_WIDTH;
        if (row_len > ROW_DEPTH)
            row_len = ROW_DEPTH;
        c = (col_pos >= ROW_DEPTH) ? 0 : col_pos;

        upper        = older_row[c];
        middle       = prev_row[c];
        older_row[c] = middle;
        prev_row[c]  = px;

        for (r = 0; r < 3; r++)
        begin
            window[3 * r]     = window[3 * r + 1];
            window[3 * r + 1] = window[3 * r + 2];
        end
        window[2] = upper;
        window[5] = middle;
        window[8] = px;

        // A full window exists from the third column of the third row on.
        if (row_pos >= 2 && c >= 2)
        begin
            med = window_median(window);
            hit = ({1'b0, med} >= threshold_setting);
            if (hit && frame_hits != COUNT_FULL)
                frame_hits = frame_hits + 1'b1;
            owed.median = med;
            owed.hit    = hit;
            owed.count  = frame_hits;
            owed.done   = last;
            owed_windows.push_back(owed);
        end

        if (c + 1 >= row_len)
        begin
            col_pos = 0;
            if (row_pos < 2)
                row_pos++;
        end
        else
        begin
            col_pos = c + 1;
        end

        // The last pixel of a frame restarts the frame state.
        if (last)
        begin
            col_pos    = 0;
            row_pos    = 0;
            frame_hits = '0;
            window     = '0;
        end
        pixel_total++;
    endtask

    // Compare one result transfer with the oldest owed result.
    task automatic check_window();
        window_result_t want;
        if (owed_windows.size() == 0)
        begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("%0t: result transfer with no window owed: median %0d flag %0b",
                         $time, median_value, at_or_above);
        end
        else
        begin
            want = owed_windows.pop_front();
            checked_total++;
            if (want.hit)
                hit_total++;
            if (median_value !== want.median || at_or_above !== want.hit ||
                match_count !== want.count || frame_done !== want.done)
            begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT)
                    $display("%0t: window mismatch, expected %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
                             $time, want.median, want.hit, want.count, want.done,
                             median_value, at_or_above, match_count, frame_done);
            end
        end
    endtask

    // Results are checked before the pixel of the same edge is taken; a
    // result can never come from a pixel transferred at that edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROW_DEPTH; k++)
            begin
                prev_row[k]  = '0;
                older_row[k] = '0;
            end
            window            = '0;
            col_pos           = 0;
            row_pos           = 0;
            frame_hits        = '0;
            width_setting     = WIDTH_RESET;
            threshold_setting = THRESH_RESET;
            owed_windows.delete();
            fail_total        = 0;
            checked_total     = 0;
            hit_total         = 0;
            pixel_total       = 0;
        end
        else
        begin
            if (pop && !empty)
                check_window();
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH: width_setting     = cfg_wdata[WIDTH_BITS-1:0];
                    REG_THRESHOLD:   threshold_setting = cfg_wdata[THRESH_BITS-1:0];
                    default:         ;
                endcase
            end
            if (push && !full)
                take_pixel(pixel, end_of_frame);
        end
        mismatches      <= fail_total;
        pending         <= owed_windows.size();
        windows_checked <= checked_total;
        windows_hit     <= hit_total;
        pixels_taken    <= pixel_total;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench top for the 3x3 median filter with threshold counter
// Drives frames of pixels and register settings into the core, pops results
// with random stalls, and lets the window checker predict and compare every
// result. Covers reset defaults, clamped widths, thresholds beyond the pixel
// range, frames that end before a full window, a width cut mid-frame, and
// a random run of frames of random size.
// ---------------------------------------------------------------------------
module tb_top
    import mtc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_PIXELS = 560;
    localparam int SETTLE_CYCLES = 16;
    localparam int FULL_ROW      = 1024;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic [7:0]               pixel;
    logic                     end_of_frame;
    logic                     push;
    logic                     full;
    logic [7:0]               median_value;
    logic                     at_or_above;
    logic [19:0]              match_count;
    logic                     frame_done;
    logic                     empty;
    logic                     pop;

    // While steady is high neither side idles.
    logic steady;
    int   stall_left;
    int   cycle_count;
    int   frames_sent;
    int   settings_written;
    int   random_pixels;

    int mismatches;
    int pending;
    int windows_checked;
    int windows_hit;
    int pixels_taken;

    median3x3_threshold_counter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .pixel        (pixel),
        .end_of_frame (end_of_frame),
        .push         (push),
        .full         (full),
        .median_value (median_value),
        .at_or_above  (at_or_above),
        .match_count  (match_count),
        .frame_done   (frame_done),
        .empty        (empty),
        .pop          (pop)
    );

    median_window_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .pixel           (pixel),
        .end_of_frame    (end_of_frame),
        .push            (push),
        .full            (full),
        .median_value    (median_value),
        .at_or_above     (at_or_above),
        .match_count     (match_count),
        .frame_done      (frame_done),
        .empty           (empty),
        .pop             (pop),
        .mismatches      (mismatches),
        .pending         (pending),
        .windows_checked (windows_checked),
        .windows_hit     (windows_hit),
        .pixels_taken    (pixels_taken)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("median3x3_threshold_counter_core verification failed");
            $finish;
        end
    end

    // Result side: short random stalls, and now and then a longer one so that
    // the output queue fills and full is raised.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (steady)
        begin
            pop <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
        end
        else if ($urandom_range(999) < 5)
        begin
            stall_left <= $urandom_range(30, 12);
            pop        <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= 4);
        end
    end

    // Mostly values near the threshold so medians fall on both sides of it.
    function automatic logic [7:0] pick_pixel(input int center);
        int roll;
        int value;
        roll = $urandom_range(99);
        if (roll < 12)
            value = ($urandom_range(1) == 1) ? 255 : 0;
        else if (roll < 50)
            value = center + int'($urandom_range(24)) - 12;
        else
            value = $urandom_range(255);
        if (value < 0)
            value = 0;
        if (value > 255)
            value = 255;
        return value[7:0];
    endfunction

    // One pixel transfer, after an optional random gap. Returns in the time
    // step of the edge that took the pixel.
    task automatic send_pixel(input logic [7:0] px, input logic last);
        int gaps;
        gaps = 0;
        while (!steady && gaps < 10 && $urandom_range(99) < 12)
            gaps++;
        if (gaps > 0)
        begin
            push <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        push         <= 1'b1;
        pixel        <= px;
        end_of_frame <= last;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic send_run(input int count, input int center, input logic closes_frame);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel(center), closes_frame && (i == count - 1));
        if (closes_frame)
            frames_sent++;
    endtask

    // Stop pushing and wait until every owed result has come out, then let
    // the pipeline settle so that pixels without a result are through too.
    task automatic drain();
        push         <= 1'b0;
        end_of_frame <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a single register and leave the other one as it is.
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] index, input int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value[CFG_DATA_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    task automatic configure(input int width_val, input int thresh_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_IMAGE_WIDTH;
        cfg_wdata <= width_val[CFG_DATA_BITS-1:0];
        @(posedge clk);
        cfg_addr  <= REG_THRESHOLD;
        cfg_wdata <= thresh_val[CFG_DATA_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    initial
    begin
        int w;
        int eff_w;
        int t;
        int len;
        int frame_total;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_IMAGE_WIDTH;
        cfg_wdata    = '0;
        pixel        = '0;
        end_of_frame = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        steady       = 1'b0;
        stall_left   = 0;
        cycle_count  = 0;
        frames_sent  = 0;
        settings_written = 0;
        random_pixels    = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset width: a short frame on 1024-pixel rows never fills a window.
        send_run(40, THRESH_RESET, 1'b1);
        drain();

        // Reset threshold: only the width changes, 128 stays in force.
        write_reg(REG_IMAGE_WIDTH, 3);
        send_run(9, THRESH_RESET, 1'b1);
        drain();

        // Width 0 acts as 3; threshold 0 counts every window.
        configure(0, 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 == 1) ? 8'd255 : 8'd0, i == 8);
        frames_sent++;
        drain();

        // Threshold above the pixel range: all-white windows are not counted.
        // Then a frame ending in the second row and one ending one pixel short
        // of a window, neither giving a result.
        configure(3, 256);
        for (int i = 0; i < 12; i++)
            send_pixel(8'd255, i == 11);
        send_run(4, 128, 1'b1);
        send_run(8, 128, 1'b1);
        frames_sent++;
        drain();

        // Width 1 acts as 3; threshold 255 counts an all-white window.
        configure(1, 255);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, i == 8);
        frames_sent++;
        drain();

        // Width cut mid-frame: the column past the new row end wraps at once.
        configure(6, 128);
        send_run(15, 128, 1'b0);
        drain();
        configure(2, 128);
        send_run(7, 128, 1'b1);
        drain();

        // Width above the store size acts as 1024: one full row with no idling,
        // then a cut to width 3 so that the third row starts right away.
        steady <= 1'b1;
        configure(2047, 64);
        send_run(FULL_ROW + 3, 64, 1'b0);
        drain();
        steady <= 1'b0;
        write_reg(REG_IMAGE_WIDTH, 3);
        send_run(4, 64, 1'b1);
        drain();

        // Random frames, mostly narrow, one or two per setting; some end early.
        while (random_pixels < RANDOM_PIXELS)
        begin
            if ($urandom_range(99) < 5)
                w = $urandom_range(2);
            else if ($urandom_range(99) < 75)
                w = $urandom_range(16, 3);
            else
                w = $urandom_range(64, 17);
            if ($urandom_range(99) < 10)
                t = $urandom_range(2047);
            else
                t = $urandom_range(256);
            configure(w, t);
            eff_w = (w < MIN_WIDTH) ? MIN_WIDTH : w;
            frame_total = $urandom_range(2, 1);
            repeat (frame_total)
            begin
                if ($urandom_range(99) < 15)
                    len = $urandom_range(2 * eff_w + 2, 1);
                else
                    len = $urandom_range(4, 2) * eff_w + $urandom_range(eff_w, 1);
                send_run(len, (t > 255) ? 255 : t, 1'b1);
                random_pixels += len;
            end
            drain();
        end

        $display("Sent %0d pixels in %0d frames under %0d register settings,",
                 pixels_taken, frames_sent, settings_written);
        $display("widths 3 to 1024 with clamping; %0d windows compared, %0d counted.",
                 windows_checked, windows_hit);
        if (mismatches == 0)
            $display("median3x3_threshold_counter_core verification clean");
        else
            $display("median3x3_threshold_counter_core verification failed");
        $finish;
    end

endmodule
